[hdl/zop_pkg.sv]
// shared types, character codes and status codes for the zoned overpunch converter
package zop_pkg;

   // default magnitude range in bits, sign included
   localparam int VALUE_WIDTH_DEFAULT = 64;
   // fixed width of the result value field
   localparam int OUT_WIDTH = 64;
   localparam int STATUS_WIDTH = 2;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;

   // character codes
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_POS_ZERO = 8'h7B;
   localparam logic [7:0] CH_NEG_ZERO = 8'h7D;
   localparam logic [7:0] CH_POS_ONE  = 8'h41;
   localparam logic [7:0] CH_POS_NINE = 8'h49;
   localparam logic [7:0] CH_NEG_ONE  = 8'h4A;
   localparam logic [7:0] CH_NEG_NINE = 8'h52;
   localparam int RADIX = 10;

   // one input beat
   typedef struct packed {
      logic [7:0] char_in;
      logic       is_first;
      logic       is_last;
   } req_data_type;

   // one result beat
   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] value;
      logic [STATUS_WIDTH-1:0]     status;
   } rsp_data_type;

   // classification of one character
   typedef struct packed {
      logic       is_digit;
      logic       is_space;
      logic       last_ok;
      logic       last_neg;
      logic [3:0] digit;
      logic [3:0] last_digit;
   } char_class_type;

endpackage

[hdl/zop_char_class.sv]
// character classifier: plain digits, blanks and overpunched sign characters
module zop_char_class (
   input  logic [7:0]              char_in,
   output zop_pkg::char_class_type char_class
);

   logic [7:0] pos_off;
   logic [7:0] neg_off;
   logic       is_pos_letter;
   logic       is_neg_letter;

   // offsets into the overpunch letter ranges
   assign pos_off = char_in - zop_pkg::CH_POS_ONE + 8'd1;
   assign neg_off = char_in - zop_pkg::CH_NEG_ONE + 8'd1;
   assign is_pos_letter = (char_in >= zop_pkg::CH_POS_ONE) && (char_in <= zop_pkg::CH_POS_NINE);
   assign is_neg_letter = (char_in >= zop_pkg::CH_NEG_ONE) && (char_in <= zop_pkg::CH_NEG_NINE);

   // plain digit and blank, then the sign-carrying last character
   always_comb begin
      char_class.is_digit   = (char_in >= zop_pkg::CH_ZERO) && (char_in <= zop_pkg::CH_NINE);
      char_class.is_space   = (char_in == zop_pkg::CH_SPACE);
      char_class.digit      = char_in[3:0];
      char_class.last_ok    = 1'b1;
      char_class.last_neg   = 1'b0;
      char_class.last_digit = 4'd0;
      priority if (char_in == zop_pkg::CH_POS_ZERO) begin
         char_class.last_digit = 4'd0;
      end else if (char_in == zop_pkg::CH_NEG_ZERO) begin
         char_class.last_neg = 1'b1;
      end else if (is_pos_letter) begin
         char_class.last_digit = pos_off[3:0];
      end else if (is_neg_letter) begin
         char_class.last_neg   = 1'b1;
         char_class.last_digit = neg_off[3:0];
      end else if ((char_in >= zop_pkg::CH_ZERO) && (char_in <= zop_pkg::CH_NINE)) begin
         char_class.last_digit = char_in[3:0];
      end else begin
         char_class.last_ok = 1'b0;
      end
   end

endmodule

[hdl/zop_accum.sv]
// field state and the times-ten-plus-digit step, with the final result
module zop_accum #(
   parameter int VALUE_WIDTH = zop_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  zop_pkg::req_data_type   item,
   input  zop_pkg::char_class_type char_class,
   output zop_pkg::rsp_data_type   result
);

   localparam int ACC_W = VALUE_WIDTH - 1;
   localparam int SUM_W = ACC_W + 4;
   localparam int PAD_W = zop_pkg::OUT_WIDTH - ACC_W;
   localparam logic [SUM_W-1:0] MAX_MAG = {{4{1'b0}}, {ACC_W{1'b1}}};

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic             ovf_ff, ovf_in;
   logic             fwb_ff, fwb_in;
   logic             ds_ff, ds_in;

   logic [ACC_W-1:0] cur_acc;
   logic             cur_bad, cur_ovf, cur_fwb, cur_ds;
   logic [3:0]       step_digit;
   logic [SUM_W-1:0] acc_wide;
   logic [SUM_W-1:0] sum;
   logic             sum_ovf;
   logic [zop_pkg::OUT_WIDTH-1:0] mag_ext;

   // a first-flagged character starts from a clean field
   always_comb begin
      if (item.is_first) begin
         cur_acc = '0;
         cur_bad = 1'b0;
         cur_ovf = 1'b0;
         cur_fwb = char_class.is_space;
         cur_ds  = 1'b0;
      end else begin
         cur_acc = acc_ff;
         cur_bad = bad_ff;
         cur_ovf = ovf_ff;
         cur_fwb = fwb_ff;
         cur_ds  = ds_ff;
      end
   end

   // acc * 10 + digit as shift-add, checked against the largest magnitude
   assign step_digit = item.is_last ? char_class.last_digit : char_class.digit;
   assign acc_wide   = {{4{1'b0}}, cur_acc};
   assign sum        = (acc_wide << 3) + (acc_wide << 1) + {{(SUM_W-4){1'b0}}, step_digit};
   assign sum_ovf    = (sum > MAX_MAG);

   // next state: the last character always returns the field to clean
   always_comb begin
      acc_in = cur_acc;
      bad_in = cur_bad;
      ovf_in = cur_ovf;
      fwb_in = cur_fwb;
      ds_in  = cur_ds;
      if (item.is_last) begin
         acc_in = '0;
         bad_in = 1'b0;
         ovf_in = 1'b0;
         fwb_in = 1'b0;
         ds_in  = 1'b0;
      end else if (char_class.is_digit) begin
         ds_in = 1'b1;
         if (!cur_ovf) begin
            if (sum_ovf) begin
               ovf_in = 1'b1;
               acc_in = '0;
            end else begin
               acc_in = sum[ACC_W-1:0];
            end
         end
      end else if (!(char_class.is_space && !cur_ds)) begin
         bad_in = 1'b1;
      end
   end

   // result for a last character
   assign mag_ext = {{PAD_W{1'b0}}, sum[ACC_W-1:0]};
   always_comb begin
      result.value  = '0;
      result.status = zop_pkg::STATUS_OK;
      priority if (cur_fwb && char_class.is_space) begin
         result.status = zop_pkg::STATUS_OK;
      end else if (cur_bad || !char_class.last_ok) begin
         result.status = zop_pkg::STATUS_BAD_CHAR;
      end else if (cur_ovf || sum_ovf) begin
         result.status = zop_pkg::STATUS_OVERFLOW;
      end else begin
         result.value = char_class.last_neg ? -mag_ext : mag_ext;
      end
   end

   // field state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
         fwb_ff <= 1'b0;
         ds_ff  <= 1'b0;
      end else if (enable) begin
         acc_ff <= acc_in;
         bad_ff <= bad_in;
         ovf_ff <= ovf_in;
         fwb_ff <= fwb_in;
         ds_ff  <= ds_in;
      end
   end

endmodule

[hdl/zoned_overpunch_to_integer_top.sv]
// top level: input register, classifier and accumulator, result register
// result path: a last-flagged beat in the input register is loaded into the result register
// once no earlier result waits there under rsp_stall, and shows on rsp from that register
// throughput: one character per cycle, set by the combinational multiply-by-ten-and-add
// a result waiting under rsp_stall blocks only a last-flagged beat, not other characters
// reset: synchronous, clears the field state and both valid flags
module zoned_overpunch_to_integer_top #(
   parameter int VALUE_WIDTH = zop_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  zop_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output zop_pkg::rsp_data_type rsp_data
);

   logic                    in_valid_ff, in_valid_in;
   zop_pkg::req_data_type   in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   zop_pkg::rsp_data_type   out_data_ff;
   zop_pkg::char_class_type char_class;
   zop_pkg::rsp_data_type   result;
   logic                    out_free;
   logic                    advance;
   logic                    accept;
   logic                    load;

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_data_ff.is_last || out_free);
   assign load      = advance && in_data_ff.is_last;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = load || (out_valid_ff && rsp_stall);

   zop_char_class u_char_class (
      .char_in    (in_data_ff.char_in),
      .char_class (char_class)
   );

   zop_accum #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .item       (in_data_ff),
      .char_class (char_class),
      .result     (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (load) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hdl/zop_checker.sv]
// port-level checks for the zoned overpunch converter, bound to the top level
module zop_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input zop_pkg::rsp_data_type rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // error results carry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != zop_pkg::STATUS_OK) |-> rsp_data.value == '0)
      else $error("error result with nonzero value");

   // only defined status codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == zop_pkg::STATUS_OK) ||
                    (rsp_data.status == zop_pkg::STATUS_BAD_CHAR) ||
                    (rsp_data.status == zop_pkg::STATUS_OVERFLOW))
      else $error("undefined status code");

   // the most negative value is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.value[zop_pkg::OUT_WIDTH-1] &&
                      (rsp_data.value[zop_pkg::OUT_WIDTH-2:0] == '0)))
      else $error("value out of magnitude range");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

endmodule

bind zoned_overpunch_to_integer_top zop_checker u_zop_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/zoned_overpunch_to_integer_top_tb.sv]
// testbench for the zoned overpunch to integer converter: directed and random fields
`timescale 1ns / 100ps

module zoned_overpunch_to_integer_top_tb;

   localparam logic [63:0] MAX_MAG = (64'd1 << (zop_pkg::VALUE_WIDTH_DEFAULT - 1)) - 64'd1;
   localparam int RANDOM_CHARS = 530;
   localparam int HOLD_CYCLES = 250;
   localparam int CYCLE_LIMIT = 200000;
   localparam string BOUNDARY_DIGITS = "922337203685477580";

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   zop_pkg::req_data_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   zop_pkg::rsp_data_type rsp_data;

   // field state of the local converter model
   logic [63:0] mag_so_far;
   logic seen_bad;
   logic seen_ovf;
   logic lead_blank;
   logic have_digits;

   zop_pkg::rsp_data_type pending_values[$];
   zop_pkg::rsp_data_type wanted;
   int failures = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;
   bit hold_off_req = 1'b0;
   int hold_left = 0;
   int phase_left = 0;
   int stall_mode = 0;

   zoned_overpunch_to_integer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic void clear_field();
      mag_so_far = '0;
      seen_bad = 1'b0;
      seen_ovf = 1'b0;
      lead_blank = 1'b0;
      have_digits = 1'b0;
   endfunction

   // mag * 10 + d, and whether it stays within the magnitude range
   function automatic bit scale_fits(input logic [63:0] mag, input logic [3:0] d,
                                     output logic [63:0] res);
      res = mag * 64'd10 + 64'(d);
      return mag <= (MAX_MAG - 64'(d)) / 64'(zop_pkg::RADIX);
   endfunction

   // advance the field state by one character, queue a value on the last one
   function automatic void convert_char(input logic [7:0] ch, input logic first,
                                        input logic last);
      logic [63:0] next_mag;
      logic [3:0] digit;
      logic neg;
      logic ok_last;
      zop_pkg::rsp_data_type outcome;
      if (first) begin
         clear_field();
         lead_blank = (ch == zop_pkg::CH_SPACE);
      end
      // characters before the last: leading blanks and digits
      if (!last) begin
         if (ch >= zop_pkg::CH_ZERO && ch <= zop_pkg::CH_NINE) begin
            have_digits = 1'b1;
            if (!seen_ovf) begin
               if (scale_fits(mag_so_far, 4'(ch - zop_pkg::CH_ZERO), next_mag)) begin
                  mag_so_far = next_mag;
               end else begin
                  seen_ovf = 1'b1;
                  mag_so_far = '0;
               end
            end
         end else if (!(ch == zop_pkg::CH_SPACE && !have_digits)) begin
            seen_bad = 1'b1;
         end
         return;
      end
      // last character: digit and sign
      ok_last = 1'b1;
      neg = 1'b0;
      digit = '0;
      if (ch == zop_pkg::CH_POS_ZERO) begin
         digit = '0;
      end else if (ch == zop_pkg::CH_NEG_ZERO) begin
         neg = 1'b1;
      end else if (ch >= zop_pkg::CH_POS_ONE && ch <= zop_pkg::CH_POS_NINE) begin
         digit = 4'(ch - zop_pkg::CH_POS_ONE + 8'd1);
      end else if (ch >= zop_pkg::CH_NEG_ONE && ch <= zop_pkg::CH_NEG_NINE) begin
         digit = 4'(ch - zop_pkg::CH_NEG_ONE + 8'd1);
         neg = 1'b1;
      end else if (ch >= zop_pkg::CH_ZERO && ch <= zop_pkg::CH_NINE) begin
         digit = 4'(ch - zop_pkg::CH_ZERO);
      end else begin
         ok_last = 1'b0;
      end
      outcome.value = '0;
      outcome.status = zop_pkg::STATUS_OK;
      // blank at both ends wins over everything else
      if (!(lead_blank && ch == zop_pkg::CH_SPACE)) begin
         if (seen_bad || !ok_last) begin
            outcome.status = zop_pkg::STATUS_BAD_CHAR;
         end else if (seen_ovf) begin
            outcome.status = zop_pkg::STATUS_OVERFLOW;
         end else if (scale_fits(mag_so_far, digit, next_mag)) begin
            outcome.value = neg ? 64'd0 - next_mag : next_mag;
         end else begin
            outcome.status = zop_pkg::STATUS_OVERFLOW;
         end
      end
      pending_values.push_back(outcome);
      clear_field();
   endfunction

   // a legal sign-carrying last character
   function automatic logic [7:0] pick_sign_char();
      unique case ($urandom_range(3, 0))
         0: return ($urandom_range(1, 0) == 1) ? zop_pkg::CH_POS_ZERO : zop_pkg::CH_NEG_ZERO;
         1: return zop_pkg::CH_POS_ONE + 8'($urandom_range(8, 0));
         2: return zop_pkg::CH_NEG_ONE + 8'($urandom_range(8, 0));
         default: return zop_pkg::CH_ZERO + 8'($urandom_range(9, 0));
      endcase
   endfunction

   // any byte, leaning toward the characters the block cares about
   function automatic logic [7:0] pick_noise_char();
      unique case ($urandom_range(3, 0))
         0: return zop_pkg::CH_SPACE;
         1: return pick_sign_char();
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // one input beat, with random gaps between bursts
   task automatic send_char(input logic [7:0] ch, input logic first, input logic last);
      int gap;
      if (burst_left == 0 && !steady_sender) begin
         burst_left = $urandom_range(30, 1);
         gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= '{char_in: ch, is_first: first, is_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      convert_char(ch, first, last);
      if (burst_left != 0) burst_left--;
   endtask

   // one field, last character flagged
   task automatic send_field(input logic [7:0] chars[$], input bit mark_first);
      for (int i = 0; i < chars.size(); i++) begin
         send_char(chars[i], mark_first && i == 0, i == chars.size() - 1);
      end
   endtask

   // the zero, one and nine sign characters, plain 0 and 9, a blank and some illegal ones as single-character fields
   task automatic test_single_chars();
      logic [7:0] singles[$];
      singles = '{zop_pkg::CH_POS_ZERO, zop_pkg::CH_NEG_ZERO, zop_pkg::CH_POS_ONE,
                  zop_pkg::CH_POS_NINE, zop_pkg::CH_NEG_ONE, zop_pkg::CH_NEG_NINE,
                  zop_pkg::CH_ZERO, zop_pkg::CH_NINE, zop_pkg::CH_SPACE, 8'h00, 8'hFF};
      foreach (singles[i]) send_char(singles[i], 1'b1, 1'b1);
   endtask

   // blank handling, blank after digits, missing first flag
   task automatic test_field_rules();
      logic [7:0] f[$];
      f = '{"1", "2", "C"};
      send_field(f, 1'b1);
      f = '{" ", "4", "}"};
      send_field(f, 1'b1);
      f = '{"1", " ", "2"};
      send_field(f, 1'b1);
      f = '{" ", " "};
      send_field(f, 1'b1);
      f = '{" ", "x", " "};
      send_field(f, 1'b1);
      // a blank with no first flag does not count as a blank start
      send_char(zop_pkg::CH_SPACE, 1'b0, 1'b1);
      f = '{" ", "7"};
      send_field(f, 1'b0);
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_full_backpressure();
      steady_sender = 1'b1;
      hold_off_req = 1'b1;
      repeat (40) send_char(pick_sign_char(), 1'b1, 1'b1);
      steady_sender = 1'b0;
   endtask

   // mostly well-formed fields, with near-limit values, blank ends and noise
   task automatic test_random_fields();
      logic [7:0] f[$];
      int sent;
      int kind;
      int n;
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         f.delete();
         kind = $urandom_range(99, 0);
         if (kind < 55) begin
            n = ($urandom_range(1, 0) == 1) ? 0 : $urandom_range(2, 1);
            repeat (n) f.push_back(zop_pkg::CH_SPACE);
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 0);
            repeat (n) f.push_back(zop_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
            f.push_back(pick_sign_char());
            send_field(f, $urandom_range(9, 0) != 0);
         end else if (kind < 70) begin
            if ($urandom_range(1, 0) == 1) begin
               for (int i = 0; i < BOUNDARY_DIGITS.len(); i++) f.push_back(BOUNDARY_DIGITS[i]);
            end else begin
               f.push_back(($urandom_range(1, 0) == 1)
                           ? zop_pkg::CH_NINE
                           : zop_pkg::CH_ZERO + 8'($urandom_range(9, 1)));
               repeat ($urandom_range(19, 16))
                  f.push_back(zop_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
            end
            // sometimes spoil a digit so that both faults meet
            if ($urandom_range(6, 0) == 0) f[$urandom_range(f.size() - 1, 0)] = pick_noise_char();
            f.push_back(pick_sign_char());
            send_field(f, 1'b1);
         end else if (kind < 78) begin
            f.push_back(zop_pkg::CH_SPACE);
            repeat ($urandom_range(4, 0)) f.push_back(pick_noise_char());
            f.push_back(zop_pkg::CH_SPACE);
            send_field(f, 1'b1);
         end else begin
            n = $urandom_range(6, 1);
            repeat (n) send_char(pick_noise_char(), $urandom_range(1, 0) == 1,
                                 $urandom_range(3, 0) == 0);
            sent += n;
         end
         sent += f.size();
      end
   endtask

   // receiver stall: random phases of differing density, plus the long hold-off
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 1);
            stall_mode = $urandom_range(3, 0);
         end else begin
            phase_left--;
         end
         unique case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            2: rsp_stall <= ($urandom_range(1, 0) == 1);
            default: rsp_stall <= ($urandom_range(4, 0) != 0);
         endcase
      end
   end

   // compare each result beat with the oldest pending value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_values.size() == 0) begin
            $error("result beat with none pending: value %0d status %0d",
                   rsp_data.value, rsp_data.status);
            failures++;
         end else begin
            wanted = pending_values.pop_front();
            if (rsp_data.value !== wanted.value) begin
               $error("value: expected %0d, got %0d", wanted.value, rsp_data.value);
               failures++;
            end
            if (rsp_data.status !== wanted.status) begin
               $error("status: expected %0d, got %0d", wanted.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      clear_field();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_single_chars();
      test_field_rules();
      test_full_backpressure();
      test_random_fields();
      req_valid <= 1'b0;
      // drain, then keep watching to catch stray beats
      while (pending_values.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
